// ===== rtl/lslf_pkg.sv =====
`default_nettype none
package lslf_pkg;

  localparam int MAX_POINTS = 32;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int UW         = 76;
  localparam int UCNT_W     = $clog2(UW);

  localparam logic [47:0] Q_MAX48 = {1'b0, {47{1'b1}}};
  localparam logic [47:0] Q_MIN48 = {1'b1, {47{1'b0}}};
  localparam logic [46:0] Q_MAX47 = {47{1'b1}};

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic ovf;
    ovf = (v[63:47] != {17{v[63]}});
    if (!ovf) return v[47:0];
    else if (v[63]) return Q_MIN48;
    else return Q_MAX48;
  endfunction

  function automatic logic [46:0] sat47(input logic [63:0] v);
    if (v[63:47] != '0) return Q_MAX47;
    else return v[46:0];
  endfunction

  // quotient magnitude to signed Q16.16, clamped to 48 bits
  function automatic logic signed [47:0] qclamp(input logic neg, input logic [UW-1:0] q);
    logic [47:0] m;
    if (!neg) begin
      if (q > UW'(Q_MAX48)) m = Q_MAX48;
      else m = q[47:0];
      return m;
    end else begin
      if (q > UW'(Q_MIN48)) m = Q_MIN48;
      else m = q[47:0];
      return -m;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lslf_mem.sv =====
`default_nettype none
module lslf_mem import lslf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [31:0]       rdata
);

  logic [31:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lslf_unit.sv =====
`default_nettype none
// shift-add multiply / restoring divide on one shared adder
module lslf_unit import lslf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire unit_req_t            req,
  input  wire logic signed [UW-1:0] op_a,
  input  wire logic signed [UW-1:0] op_b,
  output logic                      done,
  output logic signed [UW-1:0]      result
);

  typedef enum logic [1:0] {
    UST_IDLE = 2'b01,
    UST_BUSY = 2'b10
  } ust_t;

  ust_t            state_r;
  unit_op_t        op_r;
  logic            neg_r;
  logic            done_r;
  logic [UW-1:0]   acc_r;
  logic [UW-1:0]   opa_r;
  logic [UW-1:0]   opb_r;
  logic [UCNT_W-1:0] cnt_r;

  logic [UW-1:0] sh;
  logic [UW:0]   add_a;
  logic [UW:0]   add_b;
  logic          cin;
  logic [UW:0]   sum;
  logic [UW-1:0] a_mag;
  logic [UW-1:0] b_mag;

  always_comb begin
    sh = {acc_r[UW-2:0], opa_r[UW-1]};
    if (op_r == OP_DIV) begin
      add_a = {1'b0, sh};
      add_b = {1'b0, ~opb_r};
      cin   = 1'b1;
    end else begin
      add_a = {1'b0, acc_r};
      add_b = {1'b0, opa_r};
      cin   = 1'b0;
    end
    sum   = add_a + add_b + {{UW{1'b0}}, cin};
    a_mag = op_a[UW-1] ? UW'(-op_a) : UW'(op_a);
    b_mag = op_b[UW-1] ? UW'(-op_b) : UW'(op_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= UST_IDLE;
      done_r  <= 1'b0;
      op_r    <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        UST_IDLE: begin
          if (req.start) begin
            op_r    <= req.op;
            neg_r   <= op_a[UW-1] ^ op_b[UW-1];
            acc_r   <= '0;
            opa_r   <= a_mag;
            opb_r   <= b_mag;
            cnt_r   <= '0;
            state_r <= UST_BUSY;
          end
        end
        UST_BUSY: begin
          if (op_r == OP_DIV) begin
            acc_r <= sum[UW] ? sum[UW-1:0] : sh;
            opa_r <= {opa_r[UW-2:0], sum[UW]};
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == UCNT_W'(UW - 1)) begin
              done_r  <= 1'b1;
              state_r <= UST_IDLE;
            end
          end else if (opb_r == '0) begin
            done_r  <= 1'b1;
            state_r <= UST_IDLE;
          end else begin
            if (opb_r[0]) acc_r <= sum[UW-1:0];
            opa_r <= {opa_r[UW-2:0], 1'b0};
            opb_r <= {1'b0, opb_r[UW-1:1]};
          end
        end
        default: state_r <= UST_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = (op_r == OP_DIV) ? signed'(opa_r)
                : (neg_r ? signed'(-acc_r) : signed'(acc_r));

endmodule
`default_nettype wire

// ===== rtl/least_squares_line_fit.sv =====
`default_nettype none
// Least-squares line fit over a run of signed 16-bit (x,y) requests, tlast on the
// final one; up to MAX_POINTS (32) points are kept, later ones are dropped until
// tlast. Each point takes 2 serial multiplies (each stops once the remaining
// multiplier bits are zero) on the shared shift-add/divide unit; in_tready is low
// meanwhile. On tlast the fit runs six multiplies and, unless degenerate, two
// divides on the same unit, then emits one result per point (a memory read plus
// one multiply, and any output stall) and a summary result with tlast after a
// further divide for the mean. Results are Q16.16, truncated and saturated; all x
// equal sets the degenerate flag with zero fit.
module least_squares_line_fit import lslf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // x_value[15:0], y_value[31:16]
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // point_index[5:0], prediction[53:6], abs_error[100:54], slope[148:101],
  // intercept[196:149], mean_abs_error[243:197], degenerate[244], zero pad
  output logic [247:0]      out_tdata,
  output logic              out_tuser,  // item_kind
  output logic              out_tlast
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    U_XX, U_XY, U_D1, U_D2, U_S1, U_S2, U_I1, U_I2, U_SD, U_ID, U_PR, U_ERR, U_MD
  } uop_t;

  state_t              state_r;
  uop_t                uop_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]   idx_r;
  logic signed [15:0]  x_r, y_r;
  logic                fin_r;
  logic signed [21:0]  sum_x_r, sum_y_r;
  logic [35:0]         sxx_r;
  logic signed [36:0]  sxy_r;
  logic [53:0]         esum_r;
  logic signed [63:0]  t1_r, den_r, nums_r, numi_r;
  logic signed [47:0]  slope_r, icept_r, pred_r;
  logic                degen_r;
  logic                okind_r;
  logic [5:0]          oidx_r;
  logic signed [47:0]  opred_r;
  logic [46:0]         oaerr_r, omean_r;

  logic signed [15:0]  in_x, in_y, rx, ry;
  logic [31:0]         rdata;
  logic                in_acc, room;
  unit_req_t           ureq;
  logic signed [UW-1:0] ua, ub, ures;
  logic                udone;
  logic [63:0]         nums_mag, numi_mag;
  logic signed [63:0]  diff;
  logic [63:0]         diff_mag;

  assign in_x   = in_tdata[15:0];
  assign in_y   = in_tdata[31:16];
  assign rx     = rdata[15:0];
  assign ry     = rdata[31:16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign room   = (cnt_r < CNT_W'(MAX_POINTS));

  lslf_mem u_mem (
    .clk   (clk),
    .we    (in_acc && room),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    nums_mag = nums_r[63] ? 64'(-nums_r) : 64'(nums_r);
    numi_mag = numi_r[63] ? 64'(-numi_r) : 64'(numi_r);
    ureq.start = (state_r == ST_ISSUE);
    ureq.op    = OP_MUL;
    ua = '0;
    ub = '0;
    case (uop_r)
      U_XX: begin ua = UW'(x_r);  ub = UW'(x_r); end
      U_XY: begin ua = UW'(x_r);  ub = UW'(y_r); end
      U_D1: begin ua = UW'(sxx_r); ub = UW'(cnt_r); end
      U_D2: begin ua = UW'(sum_x_r); ub = UW'(sum_x_r); end
      U_S1: begin ua = UW'(sxy_r); ub = UW'(cnt_r); end
      U_S2: begin ua = UW'(sum_x_r); ub = UW'(sum_y_r); end
      U_I1: begin ua = UW'(sxx_r); ub = UW'(sum_y_r); end
      U_I2: begin ua = UW'(sxy_r); ub = UW'(sum_x_r); end
      U_SD: begin
        ua = {nums_mag[UW-17:0], 16'b0}; ub = UW'(den_r); ureq.op = OP_DIV;
      end
      U_ID: begin
        ua = {numi_mag[UW-17:0], 16'b0}; ub = UW'(den_r); ureq.op = OP_DIV;
      end
      U_PR: begin ua = UW'(slope_r); ub = UW'(rx); end
      U_MD: begin ua = UW'(esum_r); ub = UW'(cnt_r); ureq.op = OP_DIV; end
      default: begin ua = '0; ub = '0; end
    endcase
    diff     = ({{32{ry[15]}}, ry, 16'b0}) - 64'(pred_r);
    diff_mag = diff[63] ? 64'(-diff) : 64'(diff);
  end

  lslf_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .op_a   (ua),
    .op_b   (ub),
    .done   (udone),
    .result (ures)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= U_XX;
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      esum_r  <= '0;
      degen_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r   <= in_x;
            y_r   <= in_y;
            fin_r <= in_tlast;
            if (room) begin
              sum_x_r <= sum_x_r + 22'(in_x);
              sum_y_r <= sum_y_r + 22'(in_y);
              cnt_r   <= cnt_r + 1'b1;
              uop_r   <= U_XX;
              state_r <= ST_ISSUE;
            end else if (in_tlast) begin
              uop_r   <= U_D1;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: state_r <= ST_RUN;
        ST_RUN: begin
          if (uop_r == U_ERR) begin
            okind_r <= 1'b0;
            oidx_r  <= 6'(idx_r);
            opred_r <= pred_r;
            oaerr_r <= sat47(diff_mag);
            omean_r <= '0;
            state_r <= ST_OUT;
          end else if (udone) begin
            state_r <= ST_ISSUE;
            case (uop_r)
              U_XX: begin sxx_r <= sxx_r + ures[35:0]; uop_r <= U_XY; end
              U_XY: begin
                sxy_r <= sxy_r + ures[36:0];
                if (fin_r) uop_r <= U_D1;
                else state_r <= ST_IDLE;
              end
              U_D1: begin t1_r <= ures[63:0]; uop_r <= U_D2; end
              U_D2: begin den_r <= t1_r - ures[63:0]; uop_r <= U_S1; end
              U_S1: begin t1_r <= ures[63:0]; uop_r <= U_S2; end
              U_S2: begin nums_r <= t1_r - ures[63:0]; uop_r <= U_I1; end
              U_I1: begin t1_r <= ures[63:0]; uop_r <= U_I2; end
              U_I2: begin
                numi_r <= t1_r - ures[63:0];
                degen_r <= (den_r <= 0);
                if (den_r <= 0) begin
                  slope_r <= '0;
                  icept_r <= '0;
                  idx_r   <= '0;
                  state_r <= ST_FETCH;
                end else begin
                  uop_r <= U_SD;
                end
              end
              U_SD: begin slope_r <= qclamp(nums_r[63], ures); uop_r <= U_ID; end
              U_ID: begin
                icept_r <= qclamp(numi_r[63], ures);
                idx_r   <= '0;
                state_r <= ST_FETCH;
              end
              U_PR: begin
                pred_r  <= sat48(ures[63:0] + 64'(icept_r));
                uop_r   <= U_ERR;
                state_r <= ST_RUN;
              end
              U_MD: begin
                okind_r <= 1'b1;
                oidx_r  <= '0;
                opred_r <= '0;
                oaerr_r <= '0;
                omean_r <= ures[46:0];
                state_r <= ST_OUT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_FETCH: begin
          uop_r   <= U_PR;
          state_r <= ST_ISSUE;
        end
        ST_OUT: begin
          if (out_tready) begin
            if (okind_r) begin
              cnt_r   <= '0;
              sum_x_r <= '0;
              sum_y_r <= '0;
              sxx_r   <= '0;
              sxy_r   <= '0;
              esum_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              esum_r <= esum_r + 54'(oaerr_r);
              if (CNT_W'(idx_r) + 1'b1 == cnt_r) begin
                uop_r   <= U_MD;
                state_r <= ST_ISSUE;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= ST_FETCH;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tuser  = okind_r;
  assign out_tlast  = okind_r;
  assign out_tdata  = {3'b0, degen_r, omean_r, icept_r, slope_r, oaerr_r, opred_r, oidx_r};

endmodule
`default_nettype wire

// ===== rtl/lslf_checker.sv =====
`default_nettype none
module lslf_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [247:0] out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("taking requests while a result is pending");

  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser))
    else $error("tlast not on summary");

  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[100:0] == '0)
    else $error("summary carries point data");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== test/tb.sv =====
module tb;
  import lslf_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [5:0]  idx;
    logic [47:0] pred;
    logic [46:0] aerr;
    logic [47:0] slope;
    logic [47:0] icept;
    logic [46:0] mean;
    logic        degen;
    logic        last;
  } fit_result_t;

  class fit_scoreboard;
    fit_result_t pending[$];
    int          mismatches;
    longint      xs[MAX_POINTS];
    longint      ys[MAX_POINTS];
    int          count;
    longint      sx, sy, sxx, sxy;

    function void clear_run();
      count = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    endfunction

    // num * 65536 / den, truncated toward zero, saturated; den > 0
    function longint q16_div(longint num, longint den);
      logic            neg;
      longint unsigned mag, q, r, res;
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if (q >= (64'd1 << 32)) res = 64'd1 << 47;
      else res = (q << 16) + ((r << 16) / den);
      if (!neg) begin
        if (res > 64'h7FFF_FFFF_FFFF) res = 64'h7FFF_FFFF_FFFF;
        return res;
      end
      if (res > (64'd1 << 47)) res = 64'd1 << 47;
      return -longint'(res);
    endfunction

    function longint clamp48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic fin);
      longint          n, den, slope, icept, pred, diff;
      longint unsigned aerr, esum;
      logic            degen;
      fit_result_t     r;
      if (count < MAX_POINTS) begin
        xs[count] = x; ys[count] = y; count++;
        sx += x; sy += y; sxx += longint'(x) * x; sxy += longint'(x) * y;
      end
      if (!fin) return;
      n = count;
      den = n * sxx - sx * sx;
      degen = den <= 0;
      slope = 0; icept = 0; esum = 0;
      if (!degen) begin
        slope = q16_div(n * sxy - sx * sy, den);
        icept = q16_div(sy * sxx - sx * sxy, den);
      end
      for (int i = 0; i < count; i++) begin
        pred = clamp48(slope * xs[i] + icept);
        diff = ys[i] * 65536 - pred;
        aerr = diff < 0 ? -diff : diff;
        if (aerr > 64'h7FFF_FFFF_FFFF) aerr = 64'h7FFF_FFFF_FFFF;
        esum += aerr;
        r = '{1'b0, 6'(i), pred[47:0], aerr[46:0], slope[47:0], icept[47:0],
              47'd0, degen, 1'b0};
        pending.push_back(r);
      end
      esum = esum / n;
      r = '{1'b1, 6'd0, 48'd0, 47'd0, slope[47:0], icept[47:0], esum[46:0],
            degen, 1'b1};
      pending.push_back(r);
      clear_run();
    endfunction

    function void check_result(fit_result_t got);
      fit_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [247:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  fit_scoreboard board = new();
  int  quiet_cycles;
  int  idle_pct = 36;

  always #2 clk = ~clk;

  least_squares_line_fit dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_tvalid && out_tready)
        board.check_result('{out_tuser, out_tdata[5:0], out_tdata[53:6], out_tdata[100:54],
                             out_tdata[148:101], out_tdata[196:149], out_tdata[243:197],
                             out_tdata[244], out_tlast});
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {y, x};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_point(x, y, fin);
  endtask

  task automatic send_run(int len, int mode);
    logic [15:0] x, y, x0;
    x0 = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin
          x = 16'($urandom_range(200) - 100);
          y = 16'(x * 3 + $urandom_range(20));
        end
        default: begin x = x0; y = 16'($urandom); end
      endcase
      send_point(x, y, i == len - 1);
    end
  endtask

  initial begin
    board.clear_run();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_point(16'h7FFF, 16'h8000, 1);
    send_point(16'h8000, 16'h7FFF, 0);
    send_point(16'h7FFF, 16'h8000, 1);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7FFF, 16'h7FFF, 0);
    send_point(16'h0000, 16'h0000, 1);
    send_point(16'h0005, 16'h0001, 0);
    send_point(16'h0005, 16'hFFFF, 1);
    send_point(16'h7FFF, 16'h7FFF, 0);
    send_point(16'h7FFE, 16'h8000, 1);
    send_point(16'h0000, 16'h8000, 0);
    send_point(16'h0001, 16'h7FFF, 1);
    // overflow the store, last two points dropped
    for (int i = 0; i < MAX_POINTS + 2; i++)
      send_point(16'(i * 37 - 500), 16'($urandom), i == MAX_POINTS + 1);
    idle_pct = 0;
    repeat (6) send_run($urandom_range(2, 10), $urandom_range(1));
    idle_pct = 36;
    repeat (30) begin
      send_run($urandom_range(1, 12), $urandom_range(2) == 0 ? 2 : $urandom_range(1));
      if ($urandom_range(9) == 0) send_run(MAX_POINTS, 0);
    end
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
